// ===== hw/rtl/riau_pkg.sv =====
// Shared types and constants of the rational/integer arithmetic unit.
// Depends on nothing; used by the controller, GCD unit, divider, datapath and top level.
package riau_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_EQ  = 3'd4;

    // Datapath commands from the controller.
    typedef struct packed {
        logic load;       // capture operands
        logic mul1;       // first product pair
        logic mul2;       // second product pair and result combine
        logic gcd_init;   // load both GCD units from the operands
        logic gcd_step;   // one Stein step in both GCD units
        logic div_init;   // start the divisions by the GCDs
        logic div_step;   // one quotient bit in all four dividers
        logic finish;     // form the result registers
    } dp_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } dp_status_t;

endpackage

// ===== hw/rtl/rational_integer_arith_unit.sv =====
// Rational/integer arithmetic unit: top level joining controller and datapath.
// Add, subtract, multiply and divide run the load, the two multiply phases and the
// result; equality adds the Stein GCD loop and the bit-serial divider steps before
// the result. One item at a time: busy falls as done rises.
// Reset is asynchronous and clears the controller and result ports.
module rational_integer_arith_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [2:0]         func,
    input  logic               a_is_rational,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic               b_is_rational,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               res_is_rational,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic               is_equal,
    output logic               error_code
);

    // Command and status groups between the controller and the datapath.
    riau_pkg::dp_cmd_t    cmd;
    riau_pkg::dp_status_t status;
    logic                 eq_op;

    // The controller sequences each transfer: load, two multiply phases, then
    // for equality the GCD loop and the divisions, and finally the result.
    // The receiver cannot stall results, so nothing waits on the output side.
    riau_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .eq_op  (eq_op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the operands, the shared multipliers and the
    // reduction units; its result registers drive the output ports.
    riau_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .eq_op           (eq_op),
        .func            (func),
        .a_is_rational   (a_is_rational),
        .a_num           (a_num),
        .a_den           (a_den),
        .b_is_rational   (b_is_rational),
        .b_num           (b_num),
        .b_den           (b_den),
        .res_is_rational (res_is_rational),
        .res_num         (res_num),
        .res_den         (res_den),
        .is_equal        (is_equal),
        .error_code      (error_code)
    );

endmodule

// ===== hw/rtl/riau_ctrl.sv =====
// Controller state machine of the rational/integer arithmetic unit.
// Depends on riau_pkg.
module riau_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 eq_op,
    input  riau_pkg::dp_status_t status,
    output riau_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_GCD,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1     = 1'b1;
                cmd.gcd_init = 1'b1;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = eq_op ? ST_GCD : ST_FIN;
            end
            ST_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ===== hw/rtl/riau_gcd.sv =====
// Iterative binary GCD unit: one Stein step per cycle while step is high and done is low, on magnitudes.
// Depends on riau_pkg.
module riau_gcd
(
    input  logic             clk,
    input  logic             init,
    input  logic             step,
    input  riau_pkg::value_t x,
    input  riau_pkg::value_t y,
    output riau_pkg::value_t gcd,
    output logic             done
);

    localparam int KW = $clog2(riau_pkg::VALUE_WIDTH + 1);

    riau_pkg::value_t a_reg;
    riau_pkg::value_t b_reg;
    logic [KW-1:0]    k_reg;
    riau_pkg::value_t a_next;
    riau_pkg::value_t b_next;
    logic [KW-1:0]    k_next;

    assign done = (a_reg == b_reg) || (b_reg == '0) || (a_reg == '0);
    assign gcd  = ((a_reg == b_reg) || (b_reg == '0)) ? (a_reg << k_reg) : (b_reg << k_reg);

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (!a_reg[0])
        begin
            a_next = a_reg >> 1;
            if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
        end
        else if (!b_reg[0])
        begin
            b_next = b_reg >> 1;
        end
        else if (a_reg > b_reg)
        begin
            a_next = (a_reg - b_reg) >> 1;
        end
        else
        begin
            a_next = (b_reg - a_reg) >> 1;
            b_next = a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            a_reg <= x;
            b_reg <= y;
            k_reg <= '0;
        end
        else if (step && !done)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
        end
    end

endmodule

// ===== hw/rtl/riau_div.sv =====
// Restoring divider, one quotient bit per cycle while step is high, unsigned operands.
// Depends on riau_pkg.
module riau_div
(
    input  logic             clk,
    input  logic             init,
    input  logic             step,
    input  riau_pkg::value_t dividend,
    input  riau_pkg::value_t divisor,
    output riau_pkg::value_t quotient
);

    riau_pkg::value_t               q_reg;
    riau_pkg::value_t               d_reg;
    riau_pkg::value_t               r_reg;
    logic [riau_pkg::VALUE_WIDTH:0] r_shift;
    logic [riau_pkg::VALUE_WIDTH:0] r_diff;

    assign r_shift  = {r_reg, q_reg[riau_pkg::VALUE_WIDTH-1]};
    assign r_diff   = r_shift - {1'b0, d_reg};
    assign quotient = q_reg;

    // The partial remainder stays below a nonzero divisor, so VALUE_WIDTH bits hold it.
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            q_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end
        else if (step)
        begin
            if (!r_diff[riau_pkg::VALUE_WIDTH])
            begin
                r_reg <= r_diff[riau_pkg::VALUE_WIDTH-1:0];
                q_reg <= {q_reg[riau_pkg::VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift[riau_pkg::VALUE_WIDTH-1:0];
                q_reg <= {q_reg[riau_pkg::VALUE_WIDTH-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== hw/rtl/riau_dp.sv =====
// Datapath: operand registers, two shared multipliers, GCD and divider units.
// Depends on riau_pkg, riau_gcd and riau_div.
module riau_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  riau_pkg::dp_cmd_t    cmd,
    output riau_pkg::dp_status_t status,
    output logic                 eq_op,
    input  logic [2:0]           func,
    input  logic                 a_is_rational,
    input  logic signed [31:0]   a_num,
    input  logic signed [31:0]   a_den,
    input  logic                 b_is_rational,
    input  logic signed [31:0]   b_num,
    input  logic signed [31:0]   b_den,
    output logic                 res_is_rational,
    output logic signed [31:0]   res_num,
    output logic signed [31:0]   res_den,
    output logic                 is_equal,
    output logic                 error_code
);

    localparam int W  = riau_pkg::VALUE_WIDTH;
    localparam int DW = $clog2(W + 1);

    logic [2:0]       func_reg;
    logic             ar_reg;
    logic             br_reg;
    riau_pkg::value_t an_reg;
    riau_pkg::value_t ad_reg;
    riau_pkg::value_t bn_reg;
    riau_pkg::value_t bd_reg;
    riau_pkg::value_t p0_reg;
    riau_pkg::value_t p1_reg;
    riau_pkg::value_t rn_reg;
    riau_pkg::value_t rd_reg;
    logic             rat_reg;
    logic             err_reg;
    logic [DW-1:0]    cnt_reg;

    riau_pkg::value_t mul_x0;
    riau_pkg::value_t mul_y0;
    riau_pkg::value_t mul_x1;
    riau_pkg::value_t mul_y1;
    riau_pkg::value_t prod0;
    riau_pkg::value_t prod1;
    riau_pkg::value_t rn_next;
    riau_pkg::value_t rd_next;
    logic             rat_next;
    logic             err_next;

    riau_pkg::value_t an_mag;
    riau_pkg::value_t ad_mag;
    riau_pkg::value_t bn_mag;
    riau_pkg::value_t bd_mag;
    riau_pkg::value_t ga;
    riau_pkg::value_t gb;
    logic             ga_done;
    logic             gb_done;
    riau_pkg::value_t qan;
    riau_pkg::value_t qad;
    riau_pkg::value_t qbn;
    riau_pkg::value_t qbd;
    riau_pkg::value_t ran;
    riau_pkg::value_t rad;
    riau_pkg::value_t rbn;
    riau_pkg::value_t rbd;
    logic             eq_next;

    function automatic riau_pkg::value_t fit(input logic [31:0] v);
        logic [W+31:0] ext;
        begin
            ext = {{W{v[31]}}, v};
            fit = ext[W-1:0];
        end
    endfunction

    function automatic riau_pkg::value_t mag(input riau_pkg::value_t v);
        begin
            mag = v[W-1] ? (~v + 1'b1) : v;
        end
    endfunction

    function automatic logic [31:0] out32(input riau_pkg::value_t v);
        logic [W+31:0] ext;
        begin
            ext   = {{32{v[W-1]}}, v};
            out32 = ext[31:0];
        end
    endfunction

    assign eq_op = (func_reg == riau_pkg::FUNC_EQ);

    // Operand selection for the two multipliers in each phase.
    always_comb
    begin
        mul_x0 = an_reg;
        mul_y0 = bd_reg;
        mul_x1 = ad_reg;
        mul_y1 = bn_reg;
        if (cmd.mul2)
        begin
            mul_x0 = an_reg;
            mul_y0 = bn_reg;
            mul_x1 = ad_reg;
            mul_y1 = bd_reg;
        end
    end

    assign prod0 = mul_x0 * mul_y0;
    assign prod1 = mul_x1 * mul_y1;

    // Result combine: p0 = an*bd, p1 = ad*bn; prod0 = an*bn, prod1 = ad*bd.
    always_comb
    begin
        rn_next  = '0;
        rd_next  = '0;
        rat_next = 1'b0;
        err_next = 1'b0;
        case (func_reg)
            riau_pkg::FUNC_ADD, riau_pkg::FUNC_SUB:
            begin
                if (!ar_reg && !br_reg)
                begin
                    rn_next = (func_reg == riau_pkg::FUNC_ADD) ? an_reg + bn_reg
                                                               : an_reg - bn_reg;
                end
                else if (!ar_reg)
                begin
                    rat_next = 1'b1;
                    rd_next  = bd_reg;
                    rn_next  = (func_reg == riau_pkg::FUNC_ADD) ? bn_reg + p0_reg
                                                               : p0_reg - bn_reg;
                end
                else if (!br_reg)
                begin
                    rat_next = 1'b1;
                    rd_next  = ad_reg;
                    rn_next  = (func_reg == riau_pkg::FUNC_ADD) ? an_reg + p1_reg
                                                               : an_reg - p1_reg;
                end
                else if (ad_reg == bd_reg)
                begin
                    rat_next = 1'b1;
                    rd_next  = ad_reg;
                    rn_next  = (func_reg == riau_pkg::FUNC_ADD) ? an_reg + bn_reg
                                                               : an_reg - bn_reg;
                end
                else
                begin
                    rat_next = 1'b1;
                    rd_next  = prod1;
                    rn_next  = (func_reg == riau_pkg::FUNC_ADD) ? p0_reg + p1_reg
                                                               : p0_reg - p1_reg;
                end
            end
            riau_pkg::FUNC_MUL:
            begin
                rn_next  = prod0;
                rat_next = ar_reg || br_reg;
                if (ar_reg && br_reg)
                begin
                    rd_next = prod1;
                end
                else if (ar_reg)
                begin
                    rd_next = ad_reg;
                end
                else if (br_reg)
                begin
                    rd_next = bd_reg;
                end
            end
            riau_pkg::FUNC_DIV:
            begin
                rat_next = 1'b1;
                if (!ar_reg && !br_reg)
                begin
                    if (bn_reg == '0)
                    begin
                        rat_next = 1'b0;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        rn_next = an_reg;
                        rd_next = bn_reg;
                    end
                end
                else if (!ar_reg)
                begin
                    rn_next = p0_reg;
                    rd_next = bn_reg;
                end
                else if (!br_reg)
                begin
                    rn_next = an_reg;
                    rd_next = p1_reg;
                end
                else
                begin
                    rn_next = p0_reg;
                    rd_next = p1_reg;
                end
            end
            default:
            begin
                rn_next = '0;
            end
        endcase
    end

    assign an_mag = mag(an_reg);
    assign ad_mag = mag(ad_reg);
    assign bn_mag = mag(bn_reg);
    assign bd_mag = mag(bd_reg);

    riau_gcd u_gcd_a
    (
        .clk  (clk),
        .init (cmd.gcd_init),
        .step (cmd.gcd_step),
        .x    (an_mag),
        .y    (ad_mag),
        .gcd  (ga),
        .done (ga_done)
    );

    riau_gcd u_gcd_b
    (
        .clk  (clk),
        .init (cmd.gcd_init),
        .step (cmd.gcd_step),
        .x    (bn_mag),
        .y    (bd_mag),
        .gcd  (gb),
        .done (gb_done)
    );

    riau_div u_div_an (.clk(clk), .init(cmd.div_init), .step(cmd.div_step),
                       .dividend(an_mag), .divisor(ga), .quotient(qan));
    riau_div u_div_ad (.clk(clk), .init(cmd.div_init), .step(cmd.div_step),
                       .dividend(ad_mag), .divisor(ga), .quotient(qad));
    riau_div u_div_bn (.clk(clk), .init(cmd.div_init), .step(cmd.div_step),
                       .dividend(bn_mag), .divisor(gb), .quotient(qbn));
    riau_div u_div_bd (.clk(clk), .init(cmd.div_init), .step(cmd.div_step),
                       .dividend(bd_mag), .divisor(gb), .quotient(qbd));

    assign status.gcd_done = ga_done && gb_done;
    assign status.div_done = (cnt_reg == DW'(W));

    // Reduction is applied only where the GCD exceeds one; signs are restored.
    assign ran = (ga > riau_pkg::value_t'(1)) ? (an_reg[W-1] ? ~qan + 1'b1 : qan) : an_reg;
    assign rad = (ga > riau_pkg::value_t'(1)) ? (ad_reg[W-1] ? ~qad + 1'b1 : qad) : ad_reg;
    assign rbn = (gb > riau_pkg::value_t'(1)) ? (bn_reg[W-1] ? ~qbn + 1'b1 : qbn) : bn_reg;
    assign rbd = (gb > riau_pkg::value_t'(1)) ? (bd_reg[W-1] ? ~qbd + 1'b1 : qbd) : bd_reg;

    always_comb
    begin
        eq_next = 1'b0;
        if (!ar_reg && !br_reg)
        begin
            eq_next = (an_reg == bn_reg);
        end
        else if (ar_reg && br_reg)
        begin
            eq_next = (ran == rbn) && (rad == rbd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            ar_reg   <= a_is_rational;
            br_reg   <= b_is_rational;
            an_reg   <= fit(a_num);
            ad_reg   <= fit(a_den);
            bn_reg   <= fit(b_num);
            bd_reg   <= fit(b_den);
        end
        if (cmd.mul1)
        begin
            p0_reg <= prod0;
            p1_reg <= prod1;
        end
        if (cmd.mul2)
        begin
            rn_reg  <= rn_next;
            rd_reg  <= rd_next;
            rat_reg <= rat_next;
            err_reg <= err_next;
        end
        if (cmd.div_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_is_rational <= 1'b0;
            res_num         <= '0;
            res_den         <= '0;
            is_equal        <= 1'b0;
            error_code      <= 1'b0;
        end
        else if (cmd.finish)
        begin
            if (eq_op)
            begin
                res_is_rational <= 1'b0;
                res_num         <= '0;
                res_den         <= '0;
                is_equal        <= eq_next;
                error_code      <= 1'b0;
            end
            else
            begin
                res_is_rational <= rat_reg;
                res_num         <= out32(rn_reg);
                res_den         <= out32(rd_reg);
                is_equal        <= 1'b0;
                error_code      <= err_reg;
            end
        end
    end

endmodule
